// File: src/csq_pkg.sv
`default_nettype none

package csq_pkg;

    // defaults and fixed field widths
    localparam int MAX_TASKS_DEF = 16;
    localparam int COUNT_W       = 8;
    localparam int TASK_W        = 4;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;
    localparam int CFG_IDX_W     = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_TRY_TAKE = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE     = 2'd1;
    localparam logic [OP_W-1:0] OP_GIVE     = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_TAKEN   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UNAVAIL = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_QUEUED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RAISED  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_WOKEN   = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT  = 1'd1;

    // reset values of the registers
    localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = 8'd1;
    localparam logic [COUNT_W-1:0] INIT_COUNT_RST  = 8'd0;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

// File: src/csq_ram.sv
`default_nettype none

module csq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/counting_semaphore_wait_queue.sv
`default_nettype none

// channel   direction  handshake              payload
// command   in         start & !busy          opcode, task_id
// result    out        done (one-cycle pulse) status, woken_task, count_now, waiters_now
// config    in         cfg_we                 cfg_index, cfg_wdata
//
// each command is accepted in idle, which reads the head entry of the wait ring
// out of the ram; the exec state then decides and writes the ring and the counters back
// busy is high during exec; done pulses the cycle after it, when
// the next command may already be taken; no command is taken while busy is high
// the result cannot be held off by the receiver; done is high for one cycle
// reset loads a count limit of 1, init_count 0, count 0 and an empty ring;
// ring entries are never used before they are written, so no clearing pass

module counting_semaphore_wait_queue
    import csq_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [OP_W-1:0]                opcode,
    input  wire logic [TASK_W-1:0]              task_id,
    // result
    output logic                                done,
    output logic [STATUS_W-1:0]                 status,
    output logic [TASK_W-1:0]                   woken_task,
    output logic [COUNT_W-1:0]                  count_now,
    output logic [$clog2(MAX_TASKS + 1)-1:0]    waiters_now,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [COUNT_W-1:0]             cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    state_t state_reg, state_next;

    // latched command
    logic [OP_W-1:0]     op_reg;
    logic [TASK_W-1:0]   tid_reg;

    // registers and scalar state
    logic [COUNT_W-1:0]  limit_reg, limit_next;
    logic [COUNT_W-1:0]  init_count_reg, init_count_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    total_reg, total_next;

    // result registers
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TASK_W-1:0]   woken_reg, woken_next;

    // ring ram
    logic                ring_we;
    logic [TASK_W-1:0]   ring_rdata;

    logic                accept;
    logic [IDX_W-1:0]    head_inc, tail_inc;

    assign accept = start && (state_reg == ST_IDLE);

    // ring pointer wrap, any depth
    assign head_inc = (head_reg == IDX_W'(MAX_TASKS - 1)) ? '0 : head_reg + IDX_W'(1);
    assign tail_inc = (tail_reg == IDX_W'(MAX_TASKS - 1)) ? '0 : tail_reg + IDX_W'(1);

    // head entry is read on every accepted command; only a give uses it
    csq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (MAX_TASKS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (tid_reg),
        .re    (accept),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // semaphore update and result
    always_comb
    begin
        limit_next      = limit_reg;
        init_count_next = init_count_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        total_next      = total_reg;
        ring_we         = 1'b0;
        done_next       = 1'b0;
        status_next     = status_reg;
        woken_next      = woken_reg;

        if (state_reg == ST_EXEC)
        begin
            done_next   = 1'b1;
            status_next = STAT_UNAVAIL;
            woken_next  = '0;
            case (op_reg)
                OP_TRY_TAKE:
                begin
                    if (count_reg != '0)
                    begin
                        count_next  = count_reg - COUNT_W'(1);
                        status_next = STAT_TAKEN;
                    end
                end
                OP_TAKE:
                begin
                    if (count_reg != '0)
                    begin
                        count_next  = count_reg - COUNT_W'(1);
                        status_next = STAT_TAKEN;
                    end
                    else if (total_reg == CNT_W'(MAX_TASKS))
                    begin
                        // ring full: caller dropped
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ring_we     = 1'b1;
                        tail_next   = tail_inc;
                        total_next  = total_reg + CNT_W'(1);
                        status_next = STAT_QUEUED;
                    end
                end
                OP_GIVE:
                begin
                    if (total_reg != '0)
                    begin
                        woken_next  = ring_rdata;
                        head_next   = head_inc;
                        total_next  = total_reg - CNT_W'(1);
                        status_next = STAT_WOKEN;
                    end
                    else
                    begin
                        if (count_reg < limit_reg)
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        status_next = STAT_RAISED;
                    end
                end
                default:
                begin
                    // unused code: no change
                    status_next = STAT_UNAVAIL;
                end
            endcase
        end

        // a register write reloads the count and empties the ring
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_COUNT_LIMIT:
                begin
                    limit_next = (cfg_wdata == '0) ? COUNT_LIMIT_RST : cfg_wdata;
                end
                CFG_INIT_COUNT:
                begin
                    init_count_next = cfg_wdata;
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
            count_next = (init_count_next > limit_next) ? limit_next
                                                        : init_count_next;
            head_next  = '0;
            tail_next  = '0;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= COUNT_LIMIT_RST;
            init_count_reg <= INIT_COUNT_RST;
            count_reg      <= INIT_COUNT_RST;
            head_reg       <= '0;
            tail_reg       <= '0;
            total_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            init_count_reg <= init_count_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            tid_reg <= task_id;
        end
        status_reg <= status_next;
        woken_reg  <= woken_next;
    end

    assign busy        = (state_reg == ST_EXEC);
    assign done        = done_reg;
    assign status      = status_reg;
    assign woken_task  = woken_reg;
    // count and waiters settle in the same edge that raises done
    assign count_now   = count_reg;
    assign waiters_now = total_reg;

    // a result only follows an execute cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_EXEC))
        else $error("result without execute cycle");

    // the ring never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_TASKS))
        else $error("waiter total above ring depth");

    // count stays within its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= limit_reg)
        else $error("count above its limit");

    // an accepted command is executed in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted command not executed");

    // waking a waiter leaves the count alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STAT_WOKEN) |-> $stable(count_reg))
        else $error("count changed on wake");

endmodule

`default_nettype wire
